### sv/tsdr_pkg.sv
// shared types and constants for the thick segment disc rasterizer
package tsdr_pkg;
	localparam int CANVAS_WIDTH = 320;
	localparam int CANVAS_HEIGHT = 220;
	localparam int DEPTH = CANVAS_WIDTH * CANVAS_HEIGHT;
	localparam int AW = $clog2(DEPTH);
	localparam logic [9:0] ORIGIN_X_RESET = 10'd24;
	localparam logic [9:0] ORIGIN_Y_RESET = 10'd114;

	typedef enum logic [2:0] {
		REQ_SEGMENT = 3'd0,
		REQ_DISC    = 3'd1,
		REQ_ERASE   = 3'd2,
		REQ_CLEAR   = 3'd3,
		REQ_READ    = 3'd4
	} req_t;

	typedef enum logic [0:0] {
		REG_ORIGIN_X = 1'b0,
		REG_ORIGIN_Y = 1'b1
	} reg_t;

	// one pixel write request from the walker to the merge stage
	typedef struct packed {
		logic          valid;
		logic          erase;
		logic [AW-1:0] addr;
	} pix_req_t;

	function automatic logic [15:0] merge_max(input logic [15:0] d, input logic [15:0] s);
		logic [4:0] r;
		logic [5:0] g;
		logic [4:0] b;
		r = (d[15:11] > s[15:11]) ? d[15:11] : s[15:11];
		g = (d[10:5] > s[10:5]) ? d[10:5] : s[10:5];
		b = (d[4:0] > s[4:0]) ? d[4:0] : s[4:0];
		return {r, g, b};
	endfunction
endpackage

### sv/tsdr_ram.sv
// generic simple dual port ram (one write port, one read port) with registered read
module tsdr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### sv/tsdr_merge.sv
// read-modify-write pipe around the canvas memory
module tsdr_merge (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tsdr_pkg::pix_req_t      req,
	input  logic [15:0]             color,
	input  logic [tsdr_pkg::AW-1:0] rd_addr,
	output logic [15:0]             rd_data,
	output logic                    busy
);
	tsdr_pkg::pix_req_t req_s1;
	logic [15:0] mem_q;
	logic [15:0] wdata;
	logic [15:0] old;
	logic [15:0] last_q;
	logic [tsdr_pkg::AW-1:0] last_addr_q;
	logic last_v_q;

	tsdr_ram #(.WIDTH(16), .DEPTH(tsdr_pkg::DEPTH)) u_ram (
		.clk(clk), .we(req_s1.valid), .waddr(req_s1.addr), .wdata(wdata),
		.raddr(req.valid ? req.addr : rd_addr), .rdata(mem_q)
	);

	// forward the write just done when the next pixel hits the same entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= '0;
			last_v_q <= 1'b0;
		end else begin
			req_s1 <= req;
			last_v_q <= req_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		last_q <= wdata;
		last_addr_q <= req_s1.addr;
	end

	assign old = (last_v_q && last_addr_q == req_s1.addr) ? last_q : mem_q;
	assign wdata = req_s1.erase ? 16'd0 : tsdr_pkg::merge_max(old, color);
	assign rd_data = mem_q;
	assign busy = req_s1.valid;
endmodule

### sv/tsdr_walker.sv
// command sequencer: clear sweep, segment stepping, disc scanning and the read point address
module tsdr_walker (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  tsdr_pkg::req_t          req_type,
	input  logic signed [10:0]      sx,
	input  logic signed [10:0]      sy,
	input  logic signed [10:0]      ex,
	input  logic signed [10:0]      ey,
	input  logic [4:0]              radius,
	input  logic [9:0]              org_x,
	input  logic [9:0]              org_y,
	output tsdr_pkg::pix_req_t      pix,
	output logic [tsdr_pkg::AW-1:0] rd_addr,
	output logic                    rd_in,
	output logic                    done
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_CLEAR, ST_DIV, ST_DISC, ST_NEXT, ST_DONE
	} wst_t;

	wst_t st_q, st_d;
	logic [tsdr_pkg::AW-1:0] clr_q;
	logic seg_q, erase_q, final_q;
	logic signed [11:0] dx_q, dy_q;
	logic [10:0] steps_q, s_q;
	logic [11:0] s_nxt;
	logic [4:0] stride;
	// stamp centre
	logic signed [11:0] cx_q, cy_q;
	logic signed [5:0] ox_q, oy_q;
	// divider for dx*s/steps and dy*s/steps, one bit a cycle
	logic [22:0] pmag_q, qx_q;
	logic [10:0] rem_q;
	logic [4:0] dcnt_q;
	logic axis_q;
	logic neg_q;
	logic [22:0] qx_val_q;
	logic [11:0] rem_sh;
	logic signed [12:0] pxs, pys, ccx, ccy;
	logic on_canvas;
	logic [10:0] rr;
	logic [11:0] d2;
	logic [9:0] ax, ay;
	logic signed [11:0] adx, ady;
	logic [22:0] prod;
	logic signed [12:0] qs;

	assign stride = (radius[4:1] > 4'd1) ? {1'b0, radius[4:1]} : 5'd1;
	// next stamp step, one bit wider so it cannot wrap past steps
	assign s_nxt = {1'b0, s_q} + {7'd0, stride};

	assign ax = ox_q[5] ? 10'(-ox_q) : 10'(ox_q);
	assign ay = oy_q[5] ? 10'(-oy_q) : 10'(oy_q);
	assign rr = {6'd0, radius} * {6'd0, radius};
	assign d2 = {2'd0, ax} * {2'd0, ax} + {2'd0, ay} * {2'd0, ay};
	assign pxs = 13'(cx_q) + 13'(ox_q);
	assign pys = 13'(cy_q) + 13'(oy_q);
	assign ccx = pxs - 13'(org_x);
	assign ccy = pys - 13'(org_y);
	assign on_canvas = ccx >= 0 && ccy >= 0 && ccx < 13'(tsdr_pkg::CANVAS_WIDTH)
		&& ccy < 13'(tsdr_pkg::CANVAS_HEIGHT);

	// read point location
	logic signed [12:0] rx, ry;
	assign rx = 13'(sx) - 13'(org_x);
	assign ry = 13'(sy) - 13'(org_y);
	assign rd_in = rx >= 0 && ry >= 0 && rx < 13'(tsdr_pkg::CANVAS_WIDTH)
		&& ry < 13'(tsdr_pkg::CANVAS_HEIGHT);
	assign rd_addr = tsdr_pkg::AW'(ry[9:0] * tsdr_pkg::CANVAS_WIDTH) + tsdr_pkg::AW'(rx[9:0]);

	assign adx = 12'(ex) - 12'(sx);
	assign ady = 12'(ey) - 12'(sy);
	assign prod = (axis_q ? (dy_q[11] ? 12'(-dy_q) : dy_q) : (dx_q[11] ? 12'(-dx_q) : dx_q))
		* s_q;
	assign rem_sh = {rem_q, pmag_q[22]};
	assign qs = neg_q ? -13'(qx_val_q) : 13'(qx_val_q);

	always_comb begin
		st_d = st_q;
		pix = '0;
		pix.erase = erase_q;
		pix.addr = tsdr_pkg::AW'(ccy[9:0] * tsdr_pkg::CANVAS_WIDTH) + tsdr_pkg::AW'(ccx[9:0]);
		done = 1'b0;
		case (st_q)
			ST_IDLE: ;
			ST_CLEAR: begin
				pix.valid = 1'b1;
				pix.erase = 1'b1;
				pix.addr = clr_q;
				if (clr_q == tsdr_pkg::AW'(tsdr_pkg::DEPTH - 1)) st_d = ST_DONE;
			end
			ST_DIV: if (dcnt_q == 5'd23 && axis_q) st_d = ST_DISC;
			ST_DISC: begin
				pix.valid = on_canvas && d2 <= 12'(rr);
				if (ox_q == 6'(radius) && oy_q == 6'(radius)) st_d = ST_NEXT;
			end
			ST_NEXT: st_d = ST_DONE;
			ST_DONE: begin
				done = 1'b1;
				st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else if (start) begin
			case (req_type)
				tsdr_pkg::REQ_CLEAR: st_q <= ST_CLEAR;
				tsdr_pkg::REQ_SEGMENT: st_q <= (adx == 0 && ady == 0) ? ST_DISC : ST_DIV;
				tsdr_pkg::REQ_DISC, tsdr_pkg::REQ_ERASE: st_q <= ST_DISC;
				default: st_q <= ST_DONE;
			endcase
		end else if (st_q == ST_NEXT && seg_q && !final_q) begin
			st_q <= (s_nxt > {1'b0, steps_q}) ? ST_DISC : ST_DIV;
		end else st_q <= st_d;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			clr_q <= '0;
			seg_q <= req_type == tsdr_pkg::REQ_SEGMENT && !(adx == 0 && ady == 0);
			erase_q <= req_type == tsdr_pkg::REQ_ERASE;
			final_q <= 1'b0;
			dx_q <= adx;
			dy_q <= ady;
			steps_q <= 11'((adx[11] ? -adx : adx) > (ady[11] ? -ady : ady)
				? (adx[11] ? -adx : adx) : (ady[11] ? -ady : ady));
			s_q <= '0;
			cx_q <= 12'(sx);
			cy_q <= 12'(sy);
			ox_q <= -6'(radius);
			oy_q <= -6'(radius);
			dcnt_q <= '0;
			axis_q <= 1'b0;
			rem_q <= '0;
		end else begin
			case (st_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_DIV: begin
					if (dcnt_q == 5'd0) begin
						pmag_q <= prod;
						neg_q <= axis_q ? dy_q[11] : dx_q[11];
						rem_q <= '0;
						dcnt_q <= 5'd1;
					end else begin
						pmag_q <= {pmag_q[21:0], 1'b0};
						if (rem_sh >= 12'(steps_q)) begin
							rem_q <= 11'(rem_sh - 12'(steps_q));
							qx_q <= {qx_q[21:0], 1'b1};
						end else begin
							rem_q <= rem_sh[10:0];
							qx_q <= {qx_q[21:0], 1'b0};
						end
						if (dcnt_q == 5'd23) begin
							dcnt_q <= '0;
							axis_q <= !axis_q;
						end else dcnt_q <= dcnt_q + 1'b1;
					end
				end
				ST_DISC: begin
					if (ox_q == 6'(radius)) begin
						ox_q <= -6'(radius);
						oy_q <= oy_q + 1'b1;
					end else ox_q <= ox_q + 1'b1;
				end
				ST_NEXT: begin
					ox_q <= -6'(radius);
					oy_q <= -6'(radius);
					if (seg_q && !final_q) begin
						if (s_nxt > {1'b0, steps_q}) begin
							final_q <= 1'b1;
							cx_q <= 12'(ex);
							cy_q <= 12'(ey);
						end
						s_q <= s_nxt[10:0];
					end
				end
				default: ;
			endcase
			// quotient lands after the last step of each axis
			if (st_q == ST_DIV && dcnt_q == 5'd23) begin
				if (!axis_q) cx_q <= 12'(sx) + 12'(qs);
				else cy_q <= 12'(sy) + 12'(qs);
			end
		end
	end

	assign qx_val_q = {qx_q[21:0], (rem_sh >= 12'(steps_q))};
endmodule

### sv/thick_segment_disc_rasterizer.sv
// top level of the thick segment disc rasterizer
// draws segments as rows of disc stamps, discs and clear discs into a 320x220 rgb565
// canvas held in one simple dual port memory with registered read. a disc of radius r
// scans (2r+1)^2 offsets, one a cycle; a segment adds a serial division per stamp and a
// stamp every max(1,r/2) major-axis steps plus one at the end point. clear canvas sweeps
// all 70400 entries, one a cycle. the canvas is undefined until cleared. one command is in
// flight at a time; the result is held in an output register until taken
module thick_segment_disc_rasterizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// req_type[2:0] start_x[13:3] start_y[24:14] end_x[35:25] end_y[46:36]
	// radius[51:47] color[67:52], zero filled
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// pixel_value[15:0] in_canvas[16], zero filled
	output logic [23:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [9:0] org_x_q, org_y_q;
	logic busy_q, start;
	logic [2:0] req_q;
	logic signed [10:0] sx_q, sy_q, ex_q, ey_q;
	logic [4:0] rad_q;
	logic [15:0] col_q;
	tsdr_pkg::pix_req_t pix;
	logic [tsdr_pkg::AW-1:0] rd_addr;
	logic [15:0] rd_data;
	logic rd_in, done, mbusy, wdone, rd_in_q;
	logic [1:0] fin_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == tsdr_pkg::REG_ORIGIN_Y) ? {22'd0, org_y_q} : {22'd0, org_x_q};

	// config registers, written on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q <= tsdr_pkg::ORIGIN_X_RESET;
			org_y_q <= tsdr_pkg::ORIGIN_Y_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == tsdr_pkg::REG_ORIGIN_X) org_x_q <= pwdata[9:0];
			else org_y_q <= pwdata[9:0];
		end
	end

	// one command in flight, input accepted when idle and the output slot is free
	assign s_tready = !busy_q && !m_tvalid;
	assign start = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (start) begin
			req_q <= s_tdata[2:0];
			sx_q <= s_tdata[13:3];
			sy_q <= s_tdata[24:14];
			ex_q <= s_tdata[35:25];
			ey_q <= s_tdata[46:36];
			rad_q <= s_tdata[51:47];
			col_q <= s_tdata[67:52];
		end
	end

	logic start_d_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			start_d_q <= 1'b0;
			fin_q <= '0;
			m_tvalid <= 1'b0;
		end else begin
			start_d_q <= start;
			if (start) busy_q <= 1'b1;
			// let the last write drain and the read data land before the result
			fin_q <= {fin_q[0], done};
			if (fin_q[1] && !mbusy) begin
				busy_q <= 1'b0;
				m_tvalid <= 1'b1;
			end else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_q[1]) begin
			m_tdata <= {7'd0, wdone, wdone ? rd_data : 16'd0};
		end
	end

	always_ff @(posedge clk) rd_in_q <= rd_in;
	assign wdone = rd_in_q && req_q == tsdr_pkg::REQ_READ;

	tsdr_walker u_walk (
		.clk(clk), .arst_n(arst_n), .start(start_d_q), .req_type(tsdr_pkg::req_t'(req_q)),
		.sx(sx_q), .sy(sy_q), .ex(ex_q), .ey(ey_q), .radius(rad_q),
		.org_x(org_x_q), .org_y(org_y_q), .pix(pix), .rd_addr(rd_addr), .rd_in(rd_in),
		.done(done)
	);

	tsdr_merge u_merge (
		.clk(clk), .arst_n(arst_n), .req(pix), .color(col_q), .rd_addr(rd_addr),
		.rd_data(rd_data), .busy(mbusy)
	);
endmodule

### sv/tsdr_checker.sv
// port level checks for the rasterizer
module tsdr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("second transaction taken");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("ready while result pending");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:17] == 7'd0) else $error("padding bits set");
endmodule

bind thick_segment_disc_rasterizer tsdr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
